/* hw/rtl/ir_pulse_width_frame_decoder_macros.svh */
// assertion macros for the ir pulse width frame decoder
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_MACROS_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define IRPW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irpw: same-cycle check failed");

// next-cycle implication, checked outside reset
`define IRPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irpw: next-cycle check failed");

`endif

/* hw/rtl/irpw_pkg.sv */
// shared types and constants of the ir pulse width frame decoder
`default_nettype none

package irpw_pkg;

   localparam int CAPTURE_W = 16;
   localparam int BYTE_W    = 8;
   localparam int TICK_W    = 4;

   // pulse width windows in microseconds, bounds excluded
   localparam logic [CAPTURE_W-1:0] ZERO_LO   = 16'd300;
   localparam logic [CAPTURE_W-1:0] ZERO_HI   = 16'd800;
   localparam logic [CAPTURE_W-1:0] ONE_LO    = 16'd1400;
   localparam logic [CAPTURE_W-1:0] ONE_HI    = 16'd1800;
   localparam logic [CAPTURE_W-1:0] REPEAT_LO = 16'd2100;
   localparam logic [CAPTURE_W-1:0] REPEAT_HI = 16'd2500;
   localparam logic [CAPTURE_W-1:0] LEADER_LO = 16'd4200;
   localparam logic [CAPTURE_W-1:0] LEADER_HI = 16'd4700;

   localparam logic [BYTE_W-1:0] KEY_BIT_COUNT = 8'd24;
   localparam logic [BYTE_W-1:0] REPEAT_GRACE  = 8'd3;
   localparam logic [TICK_W-1:0] TICK_GRACE    = 4'd3;
   localparam logic [TICK_W-1:0] TICK_LIMIT    = 4'd9;
   localparam logic [TICK_W-1:0] TICK_SAT      = 4'd15;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_EDGE = 1'b1
   } event_kind_type;

   typedef enum logic [2:0] {
      PULSE_NONE,
      PULSE_ZERO,
      PULSE_ONE,
      PULSE_REPEAT,
      PULSE_LEADER
   } pulse_class_type;

   typedef struct packed {
      event_kind_type       kind;
      logic [CAPTURE_W-1:0] capture_count;
   } event_type;

   typedef struct packed {
      logic              key_valid;
      logic [BYTE_W-1:0] key_code;
      logic              frame_active;
      logic [BYTE_W-1:0] repeat_count;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/irpw_req_if.sv */
// request channel carrying one ir event
`default_nettype none

interface irpw_req_if
   import irpw_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [CAPTURE_W-1:0] capture_count;

   modport source (output valid, output kind, output capture_count, input ready);
   modport sink   (input valid, input kind, input capture_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/irpw_rsp_if.sv */
// result channel carrying one decoder status item
`default_nettype none

interface irpw_rsp_if
   import irpw_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              key_valid;
   logic [BYTE_W-1:0] key_code;
   logic              frame_active;
   logic [BYTE_W-1:0] repeat_count;

   modport source (output valid, output key_valid, output key_code,
                   output frame_active, output repeat_count, input ready);
   modport sink   (input valid, input key_valid, input key_code,
                   input frame_active, input repeat_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/irpw_classify.sv */
// pulse width window classifier
`default_nettype none

module irpw_classify
   import irpw_pkg::*;
(
   input  logic [CAPTURE_W-1:0] width,
   output pulse_class_type      pulse_class
);

   logic in_zero, in_one, in_repeat, in_leader;

   assign in_zero   = (width > ZERO_LO)   && (width < ZERO_HI);
   assign in_one    = (width > ONE_LO)    && (width < ONE_HI);
   assign in_repeat = (width > REPEAT_LO) && (width < REPEAT_HI);
   assign in_leader = (width > LEADER_LO) && (width < LEADER_HI);

   always_comb begin
      unique case (1'b1)
         in_zero:   pulse_class = PULSE_ZERO;
         in_one:    pulse_class = PULSE_ONE;
         in_repeat: pulse_class = PULSE_REPEAT;
         in_leader: pulse_class = PULSE_LEADER;
         default:   pulse_class = PULSE_NONE;
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/irpw_state.sv */
// frame state registers and per-event update
`default_nettype none

module irpw_state
   import irpw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  event_type       ev,
   input  pulse_class_type pulse_class,
   output result_type      result
);

   logic              frame_flag_ff,       frame_flag_in;
   logic              awaiting_falling_ff, awaiting_falling_in;
   logic [TICK_W-1:0] tick_count_ff,       tick_count_in;
   logic [BYTE_W-1:0] shift_bits_ff,       shift_bits_in;
   logic [BYTE_W-1:0] bit_count_ff,        bit_count_in;
   logic [BYTE_W-1:0] repeats_ff,          repeats_in;
   logic [BYTE_W-1:0] latched_key_ff,      latched_key_in;
   logic              counted;
   logic              key_hit;
   logic [BYTE_W-1:0] bit_count_inc;

   assign bit_count_inc = bit_count_ff + 8'd1;

   always_comb begin
      frame_flag_in       = frame_flag_ff;
      awaiting_falling_in = awaiting_falling_ff;
      tick_count_in       = tick_count_ff;
      shift_bits_in       = shift_bits_ff;
      bit_count_in        = bit_count_ff;
      repeats_in          = repeats_ff;
      latched_key_in      = latched_key_ff;
      counted             = 1'b0;
      key_hit             = 1'b0;

      if (ev.kind == KIND_TICK) begin
         if (frame_flag_ff) begin
            // timeout comes sooner when no repeat code has been seen
            if ((tick_count_ff > TICK_GRACE)
                && ((repeats_ff == '0) || (tick_count_ff > TICK_LIMIT))) begin
               frame_flag_in = 1'b0;
            end
            if (tick_count_ff < TICK_SAT) begin
               tick_count_in = tick_count_ff + 4'd1;
            end
         end
      end else if (!awaiting_falling_ff) begin
         awaiting_falling_in = 1'b1;
         tick_count_in       = '0;
      end else begin
         awaiting_falling_in = 1'b0;
         if (frame_flag_ff) begin
            case (pulse_class)
               PULSE_ZERO: begin
                  shift_bits_in = {shift_bits_ff[BYTE_W-2:0], 1'b0};
                  counted       = 1'b1;
               end
               PULSE_ONE: begin
                  shift_bits_in = {shift_bits_ff[BYTE_W-2:0], 1'b1};
                  counted       = 1'b1;
               end
               PULSE_REPEAT: begin
                  counted    = (repeats_ff > REPEAT_GRACE);
                  repeats_in = repeats_ff + 8'd1;
               end
               default: begin
               end
            endcase
         end else if (pulse_class == PULSE_LEADER) begin
            frame_flag_in = 1'b1;
            bit_count_in  = '0;
            repeats_in    = '0;
         end
      end

      if (counted) begin
         bit_count_in = bit_count_inc;
         if (bit_count_inc == KEY_BIT_COUNT) begin
            latched_key_in = shift_bits_in;
            shift_bits_in  = '0;
            key_hit        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_flag_ff       <= 1'b0;
         awaiting_falling_ff <= 1'b0;
         tick_count_ff       <= '0;
         shift_bits_ff       <= '0;
         bit_count_ff        <= '0;
         repeats_ff          <= '0;
         latched_key_ff      <= '0;
      end else if (step) begin
         frame_flag_ff       <= frame_flag_in;
         awaiting_falling_ff <= awaiting_falling_in;
         tick_count_ff       <= tick_count_in;
         shift_bits_ff       <= shift_bits_in;
         bit_count_ff        <= bit_count_in;
         repeats_ff          <= repeats_in;
         latched_key_ff      <= latched_key_in;
      end
   end

   assign result.key_valid    = key_hit;
   assign result.key_code     = latched_key_in;
   assign result.frame_active = frame_flag_in;
   assign result.repeat_count = repeats_in;

endmodule

`default_nettype wire

/* hw/rtl/ir_pulse_width_frame_decoder.sv */
// ir pulse width frame decoder top level
// req channel: one event per request, kind 0 is the 10 ms timer tick, kind 1 an
//   input capture edge; capture_count is the microsecond count since the last
//   rising edge and is only looked at on falling edges.
// rsp channel: exactly one status item per request, in order: key_valid marks
//   the request whose counted bit brings the 8-bit bit count to 24, key_code is
//   the last key byte, frame_active and repeat_count show the frame after that request.
// stages: the input register and the result register are the only stages; a
//   request's status is loaded into the result register as it leaves the
//   input register, and stays valid on rsp until taken.
// throughput: one request per cycle while rsp does not stall; the state update
//   between the two registers is combinational.
// reset (synchronous, active high) empties both stages and clears all frame
//   state, the key byte reads zero until the first key.
// when rsp stalls, the result register holds; one more request is still taken
//   into the input register, then req.ready drops until rsp moves again.
`default_nettype none
`include "ir_pulse_width_frame_decoder_macros.svh"

module ir_pulse_width_frame_decoder
   import irpw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   irpw_req_if.sink   req,
   irpw_rsp_if.source rsp
);

   logic            in_valid_ff,  in_valid_in;
   event_type       in_event_ff,  in_event_in;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff,  out_data_in;
   logic            accept;
   logic            advance;
   logic            stalled;
   logic            key_out;
   pulse_class_type pulse_class;
   result_type      step_result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_comb begin
      in_event_in = in_event_ff;
      if (accept) begin
         in_event_in.kind          = event_kind_type'(req.kind);
         in_event_in.capture_count = req.capture_count;
      end
   end

   assign out_data_in = advance ? step_result : out_data_ff;

   irpw_classify u_classify (
      .width       (in_event_ff.capture_count),
      .pulse_class (pulse_class)
   );

   irpw_state u_state (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .ev          (in_event_ff),
      .pulse_class (pulse_class),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_event_ff <= in_event_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.key_valid    = out_data_ff.key_valid;
   assign rsp.key_code     = out_data_ff.key_code;
   assign rsp.frame_active = out_data_ff.frame_active;
   assign rsp.repeat_count = out_data_ff.repeat_count;

   assign stalled = in_valid_ff && !advance;
   assign key_out = out_valid_ff && out_data_ff.key_valid;

   `IRPW_ASSERT_NOW(a_empty_stage_ready, clock, reset, !in_valid_ff, req.ready)
   `IRPW_ASSERT_NEXT(a_stage_holds, clock, reset, stalled, in_valid_ff && $stable(in_event_ff))
   `IRPW_ASSERT_NOW(a_key_inside_frame, clock, reset, key_out, out_data_ff.frame_active)

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the ir pulse width frame decoder
`timescale 1ns / 100ps

module testbench;
   import irpw_pkg::*;

   localparam int TOTAL_ITEMS = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT = 1000000;

   // predicts the decoder status for each request and checks what comes back
   class ir_frame_tracker;
      bit in_frame;
      bit falling_due;
      logic [TICK_W-1:0] ticks;
      logic [BYTE_W-1:0] shifter;
      logic [BYTE_W-1:0] bit_total;
      logic [BYTE_W-1:0] repeat_total;
      logic [BYTE_W-1:0] key_byte;
      result_type status_due[$];
      int errors;
      int keys_seen;
      int leaders_seen;
      int timeouts_seen;
      int peak_repeats;

      function new();
         in_frame = 0;
         falling_due = 0;
         ticks = '0;
         shifter = '0;
         bit_total = '0;
         repeat_total = '0;
         key_byte = '0;
         errors = 0;
         keys_seen = 0;
         leaders_seen = 0;
         timeouts_seen = 0;
         peak_repeats = 0;
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      function void note_event(event_kind_type k, logic [CAPTURE_W-1:0] w);
         bit counted;
         result_type r;
         counted = 0;
         r.key_valid = 1'b0;
         if (k == KIND_TICK) begin
            if (in_frame) begin
               if (ticks > TICK_GRACE && (repeat_total == 0 || ticks > TICK_LIMIT)) begin
                  in_frame = 0;
                  timeouts_seen++;
               end
               if (ticks < TICK_SAT) ticks = ticks + 1'b1;
            end
         end else if (!falling_due) begin
            falling_due = 1;
            ticks = '0;
         end else begin
            falling_due = 0;
            if (in_frame) begin
               if (w > ZERO_LO && w < ZERO_HI) begin
                  shifter = {shifter[BYTE_W-2:0], 1'b0};
                  counted = 1;
               end else if (w > ONE_LO && w < ONE_HI) begin
                  shifter = {shifter[BYTE_W-2:0], 1'b1};
                  counted = 1;
               end else if (w > REPEAT_LO && w < REPEAT_HI) begin
                  // repeats only start counting as bits after the grace number
                  if (repeat_total > REPEAT_GRACE) counted = 1;
                  repeat_total = repeat_total + 1'b1;
               end
            end else if (w > LEADER_LO && w < LEADER_HI) begin
               in_frame = 1;
               bit_total = '0;
               repeat_total = '0;
               leaders_seen++;
            end
         end
         if (counted) begin
            bit_total = bit_total + 1'b1;
            if (bit_total == KEY_BIT_COUNT) begin
               key_byte = shifter;
               shifter = '0;
               r.key_valid = 1'b1;
               keys_seen++;
            end
         end
         if (int'(repeat_total) > peak_repeats) peak_repeats = int'(repeat_total);
         r.key_code = key_byte;
         r.frame_active = in_frame;
         r.repeat_count = repeat_total;
         status_due.push_back(r);
      endfunction

      function void check_status(result_type got);
         result_type want;
         if (status_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: status with nothing expected: %p", $realtime, got);
            return;
         end
         want = status_due.pop_front();
         if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
             got.frame_active !== want.frame_active ||
             got.repeat_count !== want.repeat_count) begin
            errors++;
            if (errors <= 10)
               $display("%0t: status mismatch: expected %p, got %p", $realtime, want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int cycles = 0;
   int sent;
   int received;
   bit sender_slow;
   bit receiver_slow;
   ir_frame_tracker sb;

   irpw_req_if req_ch ();
   irpw_rsp_if rsp_ch ();

   ir_pulse_width_frame_decoder dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap(bit slow);
      return slow ? int'($urandom_range(0, 16)) : 0;
   endfunction

   function automatic logic [CAPTURE_W-1:0] width_in(logic [CAPTURE_W-1:0] lo,
                                                     logic [CAPTURE_W-1:0] hi);
      return CAPTURE_W'($urandom_range(lo + 1, hi - 1));
   endfunction

   function automatic logic [CAPTURE_W-1:0] any_width();
      return CAPTURE_W'($urandom_range(0, 16'hffff));
   endfunction

   // valid stays high after acceptance unless a gap follows
   task automatic send_event(event_kind_type k, logic [CAPTURE_W-1:0] w);
      int gap;
      if (sent % 64 == 0) sender_slow = 1'($urandom_range(0, 1));
      gap = pick_gap(sender_slow);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.capture_count <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_event(k, w);
      sent++;
   endtask

   // rising then falling edge, realigning the edge phase first if needed
   task automatic pulse(logic [CAPTURE_W-1:0] w);
      if (sb.falling_due) send_event(KIND_EDGE, '0);
      send_event(KIND_EDGE, any_width());
      send_event(KIND_EDGE, w);
   endtask

   task automatic end_frame();
      while (sb.in_frame) send_event(KIND_TICK, any_width());
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_frame();
      int nbits;
      int nrep;
      if ($urandom_range(0, 3) != 0) end_frame();
      pulse(width_in(LEADER_LO, LEADER_HI));
      nbits = ($urandom_range(0, 9) < 7) ? 24 : $urandom_range(0, 40);
      for (int i = 0; i < nbits; i++) begin
         if ($urandom_range(0, 15) == 0) send_event(KIND_TICK, any_width());
         if ($urandom_range(0, 40) == 0) pulse(any_width());
         if ($urandom_range(0, 1) != 0) pulse(width_in(ONE_LO, ONE_HI));
         else pulse(width_in(ZERO_LO, ZERO_HI));
      end
      nrep = $urandom_range(0, 8);
      repeat (nrep) pulse(width_in(REPEAT_LO, REPEAT_HI));
      if ($urandom_range(0, 2) != 0)
         repeat ($urandom_range(4, 12)) send_event(KIND_TICK, any_width());
   endtask

   // result side: stall per status, in slow and fast stretches
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      received = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (received % 50 == 0) receiver_slow = 1'($urandom_range(0, 1));
         stall = pick_gap(receiver_slow);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         sb.check_status('{key_valid: rsp_ch.key_valid, key_code: rsp_ch.key_code,
                           frame_active: rsp_ch.frame_active,
                           repeat_count: rsp_ch.repeat_count});
         received++;
      end
   end

   initial begin
      int random_start;
      bit drained_once;
      sb = new();
      sent = 0;
      drained_once = 0;
      sender_slow = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.capture_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: window bounds, leader handling, timeout with repeats seen
      send_event(KIND_TICK, 16'hffff);
      pulse(LEADER_LO);
      pulse(LEADER_LO + 1'b1);
      pulse(LEADER_HI - 1'b1);
      pulse(ZERO_LO);
      pulse(ZERO_HI - 1'b1);
      pulse(ONE_LO + 1'b1);
      pulse(ONE_HI);
      pulse(REPEAT_LO + 1'b1);
      pulse(REPEAT_HI);
      pulse(16'hffff);
      end_frame();

      // long frames: bit count wrapping back to a second key, repeat count wrapping
      pulse(width_in(LEADER_LO, LEADER_HI));
      repeat (300) pulse($urandom_range(0, 1) ? width_in(ONE_LO, ONE_HI)
                                              : width_in(ZERO_LO, ZERO_HI));
      end_frame();
      pulse(width_in(LEADER_LO, LEADER_HI));
      repeat (262) pulse(width_in(REPEAT_LO, REPEAT_HI));
      end_frame();

      random_start = sent;
      while (sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 6))
                  send_event($urandom_range(0, 1) ? KIND_EDGE : KIND_TICK, any_width());
            end
            2: end_frame();
            default: random_frame();
         endcase
         if (!drained_once && sent > random_start + (TOTAL_ITEMS - random_start) / 2) begin
            hold_until_drained();
            drained_once = 1;
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d requests: %0d leaders, %0d keys, %0d frame timeouts",
               sent, sb.leaders_seen, sb.keys_seen, sb.timeouts_seen);
      $display("highest repeat count %0d, %0d mismatches", sb.peak_repeats, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
